// File: design/lcs_pkg.sv
package lcs_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int ADDR_W      = 6;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRC,
        ST_SINK,
        ST_COPY,
        ST_FLUSH
    } state_t;

    // request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // output channel codes
    localparam logic CH_SOURCE = 1'b0;
    localparam logic CH_SINK   = 1'b1;

    typedef logic [2:0] idx3_t;

    // sink slot -> column
    localparam idx3_t COLUMN_ORDER [8] = '{
        3'd7, 3'd6, 3'd5, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3
    };

    // layer count -> source bit
    localparam idx3_t LAYER_ORDER [8] = '{
        3'd3, 3'd1, 3'd2, 3'd0, 3'd5, 3'd7, 3'd4, 3'd6
    };

    // bit permutation of a sink byte, chosen by column parity
    function automatic logic [7:0] lcs_permute(input logic [7:0] v, input logic odd);
        logic [7:0] r;
        if (odd)
        begin
            r = {v[0], v[2], v[4], v[6], v[7], v[5], v[3], v[1]};
        end
        else
        begin
            r = {v[7], v[5], v[3], v[1], v[0], v[2], v[4], v[6]};
        end
        return r;
    endfunction

endpackage

// File: design/led_cube_layer_scanner.sv
// tick request: 9 result bytes, the first loaded into the output register from the source state,
//   then one per cycle while out_stall is low; input is stalled until the ninth byte is in
//   the output register
// frame swap on layer wrap with a new back frame: the copy state sweeps the back buffer into
//   the shown frame and the flush state lands its last write; no request is taken meanwhile
// async active-low reset clears both frames (via per-entry valid bits) and the new mark
module led_cube_layer_scanner (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [5:0] byte_index,
    input  logic [7:0] byte_value,
    input  logic       frame_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       channel,
    output logic [2:0] column_slot,
    output logic [7:0] out_byte,
    output logic       last
);
    // (reset also clears the layer counter and display enable)
    import lcs_pkg::*;

    // sequencer and bookkeeping
    state_t             state_reg, state_next;
    logic [2:0]         slot_reg, slot_next;
    logic [2:0]         layer_reg, layer_next;
    logic               back_new_reg, back_new_next;
    logic [ADDR_W-1:0]  copy_idx_reg, copy_idx_next;
    logic               enable_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               channel_reg, channel_next;
    logic [2:0]         slot_out_reg, slot_out_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               last_reg, last_next;

    // frame memories; an entry never written reads as zero through its valid bit
    logic [7:0]             back_mem  [FRAME_BYTES];
    logic [7:0]             shown_mem [FRAME_BYTES];
    logic [FRAME_BYTES-1:0] back_valid_reg;
    logic [FRAME_BYTES-1:0] shown_valid_reg;

    // registered read ports
    logic [7:0]         back_rd_reg;
    logic               back_rd_valid_reg;
    logic [7:0]         shown_rd_reg;
    logic               shown_rd_valid_reg;

    // copy write, in the cycle after its read
    logic               pend_reg;
    logic [ADDR_W-1:0]  pend_idx_reg;

    logic               in_acc;
    logic               can_load;
    logic               back_we;
    logic               copy_rd_en;
    logic               shown_rd_en;
    logic [2:0]         rd_slot;
    logic [ADDR_W-1:0]  shown_rd_addr;
    logic [7:0]         shown_data;
    logic [7:0]         copy_data;
    logic [2:0]         cur_col;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign can_load   = !out_valid_reg || !out_stall;

    assign shown_data = shown_rd_valid_reg ? shown_rd_reg : 8'd0;
    assign copy_data  = back_rd_valid_reg ? back_rd_reg : 8'd0;
    assign cur_col    = COLUMN_ORDER[slot_reg];
    assign shown_rd_addr = {layer_reg, COLUMN_ORDER[rd_slot]};

    assign out_valid   = out_valid_reg;
    assign channel     = channel_reg;
    assign column_slot = slot_out_reg;
    assign out_byte    = out_byte_reg;
    assign last        = last_reg;

    // next state and outputs of the scan sequencer
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        layer_next     = layer_reg;
        back_new_next  = back_new_reg;
        copy_idx_next  = copy_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        channel_next   = channel_reg;
        slot_out_next  = slot_out_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        back_we        = 1'b0;
        copy_rd_en     = 1'b0;
        shown_rd_en    = 1'b0;
        rd_slot        = slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (func == FUNC_WRITE)
                    begin
                        back_we = 1'b1;
                        if (frame_last)
                        begin
                            back_new_next = 1'b1;
                        end
                    end
                    else if (enable_reg)
                    begin
                        // disabled ticks are dropped without effect
                        state_next = ST_SRC;
                    end
                end
            end

            ST_SRC:
            begin
                if (can_load)
                begin
                    // one-hot layer source byte; prefetch first sink byte
                    out_valid_next = 1'b1;
                    channel_next   = CH_SOURCE;
                    slot_out_next  = 3'd0;
                    out_byte_next  = 8'b1 << LAYER_ORDER[layer_reg];
                    last_next      = 1'b0;
                    shown_rd_en    = 1'b1;
                    slot_next      = 3'd0;
                    rd_slot        = 3'd0;
                    state_next     = ST_SINK;
                end
            end

            ST_SINK:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    channel_next   = CH_SINK;
                    slot_out_next  = slot_reg;
                    out_byte_next  = lcs_permute(shown_data, cur_col[0]);
                    last_next      = (slot_reg == 3'd7);
                    if (slot_reg != 3'd7)
                    begin
                        // fetch the byte for the following slot
                        rd_slot     = slot_reg + 3'd1;
                        shown_rd_en = 1'b1;
                        slot_next   = slot_reg + 3'd1;
                    end
                    else
                    begin
                        slot_next  = 3'd0;
                        layer_next = layer_reg + 3'd1;
                        if (layer_reg == 3'd7 && back_new_reg)
                        begin
                            // wrap with a fresh back buffer: start the copy sweep
                            back_new_next = 1'b0;
                            copy_idx_next = '0;
                            state_next    = ST_COPY;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_COPY:
            begin
                copy_rd_en    = 1'b1;
                copy_idx_next = copy_idx_reg + ADDR_W'(1);
                if (copy_idx_reg == ADDR_W'(FRAME_BYTES - 1))
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                // last copy write lands at this edge
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            slot_reg           <= 3'd0;
            layer_reg          <= 3'd0;
            back_new_reg       <= 1'b0;
            copy_idx_reg       <= '0;
            enable_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
            back_valid_reg     <= '0;
            shown_valid_reg    <= '0;
            back_rd_valid_reg  <= 1'b0;
            shown_rd_valid_reg <= 1'b0;
            pend_reg           <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            layer_reg     <= layer_next;
            back_new_reg  <= back_new_next;
            copy_idx_reg  <= copy_idx_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= copy_rd_en;
            if (cfg_write)
            begin
                enable_reg <= cfg_data;
            end
            if (back_we)
            begin
                back_valid_reg[byte_index] <= 1'b1;
            end
            if (copy_rd_en)
            begin
                back_rd_valid_reg <= back_valid_reg[copy_idx_reg];
            end
            if (shown_rd_en)
            begin
                shown_rd_valid_reg <= shown_valid_reg[shown_rd_addr];
            end
            if (pend_reg)
            begin
                shown_valid_reg[pend_idx_reg] <= 1'b1;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        channel_reg  <= channel_next;
        slot_out_reg <= slot_out_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        pend_idx_reg <= copy_idx_reg;
    end

    // back buffer: write port for requests, read port for the copy sweep
    always_ff @(posedge clk)
    begin
        if (back_we)
        begin
            back_mem[byte_index] <= byte_value;
        end
        if (copy_rd_en)
        begin
            back_rd_reg <= back_mem[copy_idx_reg];
        end
    end

    // shown frame: write port for the copy sweep, read port for the scan
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            shown_mem[pend_idx_reg] <= copy_data;
        end
        if (shown_rd_en)
        begin
            shown_rd_reg <= shown_mem[shown_rd_addr];
        end
    end

endmodule

// File: design/lcs_checker.sv
module lcs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       channel,
    input logic [2:0] column_slot,
    input logic [7:0] out_byte,
    input logic       last
);
    import lcs_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(column_slot)
                                   && $stable(channel) && $stable(last))
    else $error("stalled result changed");

    // source byte is one-hot, slot zero, never last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && channel == CH_SOURCE |-> $onehot(out_byte) && column_slot == 3'd0 && !last)
    else $error("bad source byte");

    // last marks only the eighth sink byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (last || (channel == CH_SINK && column_slot == 3'd7))
        |-> last && channel == CH_SINK && column_slot == 3'd7)
    else $error("last misplaced");

    // once a byte of a tick is taken, the next one of the tick follows at once
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last
        |=> out_valid && channel == CH_SINK
            && column_slot == ($past(channel) == CH_SOURCE ? 3'd0 : $past(column_slot) + 3'd1))
    else $error("sink sequence broken");

    // no request taken while a tick is unfinished
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
    else $error("request taken mid tick");

endmodule

bind led_cube_layer_scanner lcs_checker u_lcs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .channel     (channel),
    .column_slot (column_slot),
    .out_byte    (out_byte),
    .last        (last)
);
